// ===== hdl/graph_depth_first_path_search_unit_macros.svh =====
// Assertion macros for the depth-first path search unit.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef GRAPH_DEPTH_FIRST_PATH_SEARCH_UNIT_MACROS_SVH
`define GRAPH_DEPTH_FIRST_PATH_SEARCH_UNIT_MACROS_SVH

// Condition implies property in the same cycle.
`define GDFS_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Condition implies property in the following cycle.
`define GDFS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hdl/gdfs_pkg.sv =====
// Shared constants for the depth-first path search unit.
// No dependencies.
package gdfs_pkg;

    localparam int VTX_W = 6;
    localparam int VTX_N = 64;
    localparam int TOP_W = 7;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_BADV = 2'd3;

endpackage

// ===== hdl/gdfs_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// No package dependencies.
module gdfs_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 9
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/graph_depth_first_path_search_unit.sv =====
// Depth-first path search unit: edge-list graph store and search sequencer.
// Depends on gdfs_pkg, gdfs_ram and graph_depth_first_path_search_unit_macros.svh.
//
//  channel | direction | handshake           | payload
//  cmd     | in        | cmd_valid/cmd_stall | command, first_vertex, second_vertex
//  res     | out       | res_valid/res_stall | status, path_depth
//
// Clear, ignored and rejected items go from idle straight to the result state,
// an add through the edge write first. A search reads the source head, then an
// edge check and edge read per edge, a head read per vertex pushed and a check
// and pop per vertex popped, as edge, head and stack memories read once a cycle.
// Reset empties the graph at once (head valid bits); no clearing pass.
// A new item is taken while the previous result waits under res_stall.
module graph_depth_first_path_search_unit #(
    parameter int MAX_VERTICES = 63,
    parameter int MAX_EDGES    = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_stall,
    input  logic [1:0]              command,
    input  logic [gdfs_pkg::VTX_W-1:0] first_vertex,
    input  logic [gdfs_pkg::VTX_W-1:0] second_vertex,
    output logic                    res_valid,
    input  logic                    res_stall,
    output logic [1:0]              status,
    output logic [gdfs_pkg::VTX_W-1:0] path_depth
);

    `include "graph_depth_first_path_search_unit_macros.svh"

    localparam int VW  = gdfs_pkg::VTX_W;
    localparam int TW  = gdfs_pkg::TOP_W;
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int ELW = $clog2(MAX_EDGES + 1);
    localparam logic [ELW-1:0] EDGE_NULL = ELW'(MAX_EDGES);
    localparam logic [7:0]     VMAX      = 8'(MAX_VERTICES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_WR,
        S_SRC_HEAD,
        S_EDGE,
        S_EREAD,
        S_HEAD,
        S_POP,
        S_DONE
    } state_t;

    state_t                       state_reg, state_next;
    logic [gdfs_pkg::VTX_N-1:0]   head_valid_reg, head_valid_next;
    logic [gdfs_pkg::VTX_N-1:0]   visited_reg, visited_next;
    logic [ELW-1:0]               used_reg, used_next;
    logic [ELW-1:0]               cur_e_reg, cur_e_next;
    logic [TW-1:0]                top_reg, top_next;
    logic [VW-1:0]                a_reg, a_next;
    logic [VW-1:0]                b_reg, b_next;
    logic [VW-1:0]                w_reg, w_next;
    logic [1:0]                   rs_status_reg, rs_status_next;
    logic [VW-1:0]                rs_depth_reg, rs_depth_next;
    logic                         res_valid_reg, res_valid_next;
    logic [1:0]                   status_reg, status_next;
    logic [VW-1:0]                depth_reg, depth_next;

    // memory ports
    logic                 head_we;
    logic [VW-1:0]        head_wa, head_ra;
    logic [ELW-1:0]       head_wd, head_q;
    logic                 edge_we;
    logic [EW-1:0]        edge_wa, edge_ra;
    logic [VW+ELW-1:0]    edge_wd, edge_q;
    logic                 stk_we;
    logic [VW-1:0]        stk_wa, stk_ra;
    logic [ELW-1:0]       stk_wd, stk_q;

    logic                 vok;
    logic [VW-1:0]        edge_tgt;
    logic [ELW-1:0]       edge_link;

    gdfs_ram #(.DEPTH(gdfs_pkg::VTX_N), .WIDTH(ELW)) u_head (
        .clk(clk), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
        .rd_addr(head_ra), .rd_data(head_q)
    );

    gdfs_ram #(.DEPTH(MAX_EDGES), .WIDTH(VW + ELW)) u_edge (
        .clk(clk), .wr_en(edge_we), .wr_addr(edge_wa), .wr_data(edge_wd),
        .rd_addr(edge_ra), .rd_data(edge_q)
    );

    gdfs_ram #(.DEPTH(gdfs_pkg::VTX_N), .WIDTH(ELW)) u_stack (
        .clk(clk), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
        .rd_addr(stk_ra), .rd_data(stk_q)
    );

    assign edge_tgt  = edge_q[VW+ELW-1:ELW];
    assign edge_link = edge_q[ELW-1:0];

    assign vok = (first_vertex != '0) && ({2'b00, first_vertex} <= VMAX) &&
                 (second_vertex != '0) && ({2'b00, second_vertex} <= VMAX);

    assign cmd_stall  = (state_reg != S_IDLE);
    assign res_valid  = res_valid_reg;
    assign status     = status_reg;
    assign path_depth = depth_reg;

    // fixed memory addressing
    assign head_ra = (state_reg == S_EREAD) ? edge_tgt : first_vertex;
    assign edge_ra = cur_e_reg[EW-1:0];
    assign stk_ra  = VW'(top_reg - TW'(2));

    always_comb
    begin
        state_next      = state_reg;
        head_valid_next = head_valid_reg;
        visited_next    = visited_reg;
        used_next       = used_reg;
        cur_e_next      = cur_e_reg;
        top_next        = top_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        w_next          = w_reg;
        rs_status_next  = rs_status_reg;
        rs_depth_next   = rs_depth_reg;
        res_valid_next  = res_valid_reg && res_stall;
        status_next     = status_reg;
        depth_next      = depth_reg;

        head_we = 1'b0;
        head_wa = a_reg;
        head_wd = used_reg;
        edge_we = 1'b0;
        edge_wa = used_reg[EW-1:0];
        edge_wd = {b_reg, head_valid_reg[a_reg] ? head_q : EDGE_NULL};
        stk_we  = 1'b0;
        stk_wa  = VW'(top_reg - TW'(1));
        stk_wd  = edge_link;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    a_next         = first_vertex;
                    b_next         = second_vertex;
                    rs_status_next = gdfs_pkg::ST_OK;
                    rs_depth_next  = '0;
                    state_next     = S_DONE;
                    case (command)
                        gdfs_pkg::CMD_CLEAR:
                        begin
                            head_valid_next = '0;
                            used_next       = '0;
                        end
                        gdfs_pkg::CMD_ADD:
                        begin
                            if (!vok)
                                rs_status_next = gdfs_pkg::ST_BADV;
                            else if (used_reg >= EDGE_NULL)
                                rs_status_next = gdfs_pkg::ST_FULL;
                            else
                                state_next = S_ADD_WR;
                        end
                        gdfs_pkg::CMD_SEARCH:
                        begin
                            if (!vok)
                            begin
                                rs_status_next = gdfs_pkg::ST_BADV;
                            end
                            else
                            begin
                                visited_next               = '0;
                                visited_next[first_vertex] = 1'b1;
                                state_next                 = S_SRC_HEAD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ADD_WR:
            begin
                // new edge goes to the front of the source list
                edge_we                 = 1'b1;
                head_we                 = 1'b1;
                head_valid_next[a_reg]  = 1'b1;
                used_next               = used_reg + ELW'(1);
                state_next              = S_DONE;
            end
            S_SRC_HEAD:
            begin
                stk_we     = 1'b1;
                stk_wa     = '0;
                stk_wd     = head_valid_reg[a_reg] ? head_q : EDGE_NULL;
                cur_e_next = stk_wd;
                top_next   = TW'(1);
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                if (cur_e_reg >= EDGE_NULL)
                begin
                    top_next = top_reg - TW'(1);
                    if (top_reg == TW'(1))
                    begin
                        rs_status_next = gdfs_pkg::ST_MISS;
                        rs_depth_next  = '0;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
                else
                begin
                    state_next = S_EREAD;
                end
            end
            S_EREAD:
            begin
                // advance this frame past the edge just read
                stk_we     = 1'b1;
                cur_e_next = edge_link;
                if (visited_reg[edge_tgt])
                begin
                    state_next = S_EDGE;
                end
                else if (edge_tgt == b_reg)
                begin
                    // walk-tree depth of the target equals the stack height
                    rs_status_next = gdfs_pkg::ST_OK;
                    rs_depth_next  = top_reg[VW-1:0];
                    state_next     = S_DONE;
                end
                else
                begin
                    visited_next[edge_tgt] = 1'b1;
                    w_next                 = edge_tgt;
                    state_next             = S_HEAD;
                end
            end
            S_HEAD:
            begin
                stk_we     = 1'b1;
                stk_wa     = top_reg[VW-1:0];
                stk_wd     = head_valid_reg[w_reg] ? head_q : EDGE_NULL;
                cur_e_next = stk_wd;
                top_next   = top_reg + TW'(1);
                state_next = S_EDGE;
            end
            S_POP:
            begin
                cur_e_next = stk_q;
                state_next = S_EDGE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    status_next    = rs_status_reg;
                    depth_next     = rs_depth_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_valid_reg <= '0;
            visited_reg    <= '0;
            used_reg       <= '0;
            top_reg        <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_valid_reg <= head_valid_next;
            visited_reg    <= visited_next;
            used_reg       <= used_next;
            top_reg        <= top_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_e_reg     <= cur_e_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        w_reg         <= w_next;
        rs_status_reg <= rs_status_next;
        rs_depth_reg  <= rs_depth_next;
        status_reg    <= status_next;
        depth_reg     <= depth_next;
    end

    `GDFS_ASSERT_IMPLY(a_used_bound, 1'b1, used_reg <= EDGE_NULL, "edge count past store size")
    `GDFS_ASSERT_IMPLY(a_stack_live, state_reg == S_EDGE || state_reg == S_EREAD,
        top_reg != '0, "walking with an empty stack")
    `GDFS_ASSERT_IMPLY(a_src_marked, state_reg == S_EDGE, visited_reg[a_reg],
        "search source not marked visited")
    `GDFS_ASSERT_NEXT(a_res_from_done, !res_valid_reg && state_reg != S_DONE, !res_valid_reg,
        "result raised outside completion")

endmodule
